// ===== hw/rtl/vfc_pkg.sv =====
// Shared types, constants and the texture layer lookup for the voxel face culling unit.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package vfc_pkg;

   // Default chunk geometry and number of type rows that may carry a texture.
   localparam int DEF_XZ_SIZE   = 16;
   localparam int DEF_Y_SIZE    = 64;
   localparam int DEF_TYPE_ROWS = 24;

   // Rows of the built-in texture table; types at or above this give layer 0.
   localparam int TEX_ROWS = 24;

   // Widest coordinates over the supported geometry range, used in queued commands.
   localparam int XZ_MAX_W = 6;
   localparam int Y_MAX_W  = 8;

   localparam int TYPE_W  = 8;
   localparam int LAYER_W = 5;
   localparam int FACE_W  = 3;
   localparam int FACES   = 6;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [FACE_W-1:0] {
      FACE_FRONT  = 3'd0,
      FACE_RIGHT  = 3'd1,
      FACE_TOP    = 3'd2,
      FACE_LEFT   = 3'd3,
      FACE_BOTTOM = 3'd4,
      FACE_BACK   = 3'd5
   } face_type;

   // Register indexes of the configuration port.
   localparam logic REG_CULLING_ON = 1'b0;
   localparam logic REG_AIR_CODE   = 1'b1;

   typedef struct packed {
      op_type              op;
      logic [XZ_MAX_W-1:0] x;
      logic [Y_MAX_W-1:0]  y;
      logic [XZ_MAX_W-1:0] z;
      logic [TYPE_W-1:0]   btype;
   } cmd_type;

   // Texture layer of one face of one block type.
   function automatic logic [LAYER_W-1:0] tex_layer(input logic [TYPE_W-1:0] btype,
                                                    input logic [FACE_W-1:0] face);
      logic [LAYER_W-1:0] layer;
      unique case (btype)
         8'd1: begin
            if (face == FACE_TOP) begin
               layer = 5'd1;
            end else if (face == FACE_BOTTOM) begin
               layer = 5'd3;
            end else begin
               layer = 5'd2;
            end
         end
         8'd2:    layer = 5'd4;
         8'd3:    layer = 5'd5;
         8'd4:    layer = 5'd3;
         8'd5:    layer = 5'd5;
         8'd6:    layer = 5'd6;
         8'd7:    layer = 5'd7;
         8'd8:    layer = 5'd8;
         8'd9:    layer = 5'd9;
         8'd10:   layer = 5'd10;
         8'd11:   layer = 5'd11;
         8'd12:   layer = 5'd12;
         8'd13:   layer = 5'd20;
         default: layer = 5'd0;
      endcase
      return layer;
   endfunction

endpackage

// ===== hw/rtl/vfc_front.sv =====
// Front end of the voxel face culling unit: accepts requests, range checks and classifies them.
// Depends on vfc_pkg; feeds vfc_queue.
`timescale 1ns / 1ps

module vfc_front #(
   parameter int XZ_SIZE = vfc_pkg::DEF_XZ_SIZE,
   parameter int Y_SIZE  = vfc_pkg::DEF_Y_SIZE,
   localparam int XZ_W = $clog2(XZ_SIZE),
   localparam int Y_W  = $clog2(Y_SIZE)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic [XZ_W-1:0]           req_pos_x,
   input  logic [Y_W-1:0]            req_pos_y,
   input  logic [XZ_W-1:0]           req_pos_z,
   input  logic [vfc_pkg::TYPE_W-1:0] req_block_type,
   input  logic                      clearing,
   output logic                      push_valid,
   input  logic                      push_ready,
   output vfc_pkg::cmd_type          push_cmd
);
   import vfc_pkg::*;

   logic in_range;
   logic dropped_ff;
   logic dropped_in;

   // Coordinates outside the chunk are taken and dropped without reaching the back end.
   assign in_range = ({1'b0, req_pos_x} < (XZ_W + 1)'(XZ_SIZE)) &&
                     ({1'b0, req_pos_y} < (Y_W + 1)'(Y_SIZE)) &&
                     ({1'b0, req_pos_z} < (XZ_W + 1)'(XZ_SIZE));

   assign req_ready  = !clearing && push_ready;
   assign push_valid = req_valid && !clearing && in_range;

   always_comb begin
      push_cmd.op    = op_type'(req_func);
      push_cmd.x     = XZ_MAX_W'(req_pos_x);
      push_cmd.y     = Y_MAX_W'(req_pos_y);
      push_cmd.z     = XZ_MAX_W'(req_pos_z);
      push_cmd.btype = req_block_type;
   end

   // Flags that the last accepted request was dropped; kept as a status bit for debug.
   assign dropped_in = (req_valid && req_ready) ? !in_range : dropped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dropped_ff <= 1'b0;
      end else begin
         dropped_ff <= dropped_in;
      end
   end

endmodule

// ===== hw/rtl/vfc_queue.sv =====
// Short command queue between the front and back ends of the voxel face culling unit.
// Depends on vfc_pkg for the command type and depth.
`timescale 1ns / 1ps

module vfc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  vfc_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output vfc_pkg::cmd_type pop_cmd
);
   import vfc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/vfc_back.sv =====
// Back end of the voxel face culling unit: owns the voxel memory, runs the clearing pass,
// executes writes and queries and drives the result register. Depends on vfc_pkg.
`timescale 1ns / 1ps

module vfc_back #(
   parameter int XZ_SIZE   = vfc_pkg::DEF_XZ_SIZE,
   parameter int Y_SIZE    = vfc_pkg::DEF_Y_SIZE,
   parameter int TYPE_ROWS = vfc_pkg::DEF_TYPE_ROWS,
   localparam int XZ_W = $clog2(XZ_SIZE),
   localparam int Y_W  = $clog2(Y_SIZE)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        culling_on,
   input  logic [vfc_pkg::TYPE_W-1:0]  air_code,
   output logic                        clearing,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  vfc_pkg::cmd_type            pop_cmd,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [XZ_W-1:0]             rsp_face_x,
   output logic [Y_W-1:0]              rsp_face_y,
   output logic [XZ_W-1:0]             rsp_face_z,
   output logic [vfc_pkg::FACE_W-1:0]  rsp_face_id,
   output logic [vfc_pkg::LAYER_W-1:0] rsp_texture_layer,
   output logic                        rsp_last_face
);
   import vfc_pkg::*;

   localparam int AW = Y_W + 2 * XZ_W;
   localparam logic [FACE_W-1:0] DIR_DONE = FACE_W'(FACES);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_EMIT
   } state_type;

   // Voxel memory, addressed as {y, x, z}.
   logic [TYPE_W-1:0] mem [2**AW];
   logic              mem_we;
   logic              mem_re;
   logic [AW-1:0]     mem_addr;
   logic [TYPE_W-1:0] mem_wdata;
   logic [TYPE_W-1:0] rd_data_ff;

   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic [XZ_W-1:0]    cx_ff, cx_in;
   logic [Y_W-1:0]     cy_ff, cy_in;
   logic [XZ_W-1:0]    cz_ff, cz_in;
   logic [FACE_W-1:0]  dir_ff, dir_in;
   logic [TYPE_W-1:0]  type_ff, type_in;
   logic [FACES-1:0]   hidden_ff, hidden_in;
   logic [FACES-1:0]   rem_ff, rem_in;
   logic               inb_ff, inb_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [XZ_W-1:0]    rsp_x_ff, rsp_x_in;
   logic [Y_W-1:0]     rsp_y_ff, rsp_y_in;
   logic [XZ_W-1:0]    rsp_z_ff, rsp_z_in;
   logic [FACE_W-1:0]  rsp_face_ff, rsp_face_in;
   logic [LAYER_W-1:0] rsp_layer_ff, rsp_layer_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [XZ_W-1:0]    nx;
   logic [Y_W-1:0]     ny;
   logic [XZ_W-1:0]    nz;
   logic               nb_inb;
   logic [FACES-1:0]   hid_next;
   logic [FACES-1:0]   vis_next;
   logic [FACES-1:0]   pick_oh;
   logic [FACE_W-1:0]  pick_idx;
   logic               slot_free;
   logic               has_row;

   assign clearing  = (state_ff == ST_CLEAR);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign has_row   = ({1'b0, type_ff} < (TYPE_W + 1)'(TYPE_ROWS));

   // Neighbor of the current voxel in direction dir_ff, and whether it lies in the chunk.
   always_comb begin
      nx     = cx_ff;
      ny     = cy_ff;
      nz     = cz_ff;
      nb_inb = 1'b0;
      unique case (dir_ff)
         FACE_FRONT: begin
            nz     = cz_ff + XZ_W'(1);
            nb_inb = (cz_ff != XZ_W'(XZ_SIZE - 1));
         end
         FACE_RIGHT: begin
            nx     = cx_ff + XZ_W'(1);
            nb_inb = (cx_ff != XZ_W'(XZ_SIZE - 1));
         end
         FACE_TOP: begin
            ny     = cy_ff + Y_W'(1);
            nb_inb = (cy_ff != Y_W'(Y_SIZE - 1));
         end
         FACE_LEFT: begin
            nx     = cx_ff - XZ_W'(1);
            nb_inb = (cx_ff != '0);
         end
         FACE_BOTTOM: begin
            ny     = cy_ff - Y_W'(1);
            nb_inb = (cy_ff != '0);
         end
         FACE_BACK: begin
            nz     = cz_ff - XZ_W'(1);
            nb_inb = (cz_ff != '0);
         end
         default: begin
            nb_inb = 1'b0;
         end
      endcase
   end

   // The read returning this cycle belongs to face dir_ff - 1.
   always_comb begin
      hid_next = hidden_ff;
      for (int i = 0; i < FACES; i++) begin
         if (dir_ff == FACE_W'(i + 1)) begin
            hid_next[i] = !inb_ff || (rd_data_ff != air_code);
         end
      end
      vis_next = culling_on ? ~hid_next : {FACES{1'b1}};
   end

   // Lowest face still to be emitted.
   always_comb begin
      pick_idx = '0;
      for (int i = FACES - 1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            pick_idx = FACE_W'(i);
         end
      end
      pick_oh = rem_ff & (~rem_ff + FACES'(1));
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      dir_in       = dir_ff;
      type_in      = type_ff;
      hidden_in    = hidden_ff;
      rem_in       = rem_ff;
      inb_in       = inb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_face_in  = rsp_face_ff;
      rsp_layer_in = rsp_layer_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = '0;
      mem_wdata    = '0;
      pop_ready    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_addr    = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            pop_ready = 1'b1;
            mem_addr  = {pop_cmd.y[Y_W-1:0], pop_cmd.x[XZ_W-1:0], pop_cmd.z[XZ_W-1:0]};
            mem_wdata = pop_cmd.btype;
            if (pop_valid) begin
               if (pop_cmd.op == OP_WRITE) begin
                  mem_we = 1'b1;
               end else begin
                  mem_re    = 1'b1;
                  cx_in     = pop_cmd.x[XZ_W-1:0];
                  cy_in     = pop_cmd.y[Y_W-1:0];
                  cz_in     = pop_cmd.z[XZ_W-1:0];
                  dir_in    = FACE_FRONT;
                  hidden_in = '0;
                  state_in  = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            mem_re    = (dir_ff != DIR_DONE);
            mem_addr  = {ny, nx, nz};
            inb_in    = nb_inb;
            hidden_in = hid_next;
            dir_in    = dir_ff + FACE_W'(1);
            if (dir_ff == FACE_FRONT) begin
               // Center voxel arrives first; an air voxel ends the query here.
               type_in = rd_data_ff;
               if (rd_data_ff == air_code) begin
                  state_in = ST_IDLE;
               end
            end else if (dir_ff == DIR_DONE) begin
               rem_in   = vis_next;
               state_in = (vis_next == '0) ? ST_IDLE : ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = cx_ff;
               rsp_y_in     = cy_ff;
               rsp_z_in     = cz_ff;
               rsp_face_in  = pick_idx;
               rsp_layer_in = has_row ? tex_layer(type_ff, pick_idx) : '0;
               rsp_last_in  = ((rem_ff & ~pick_oh) == '0);
               rem_in       = rem_ff & ~pick_oh;
               if ((rem_ff & ~pick_oh) == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         dir_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      type_ff      <= type_in;
      hidden_ff    <= hidden_in;
      rem_ff       <= rem_in;
      inb_ff       <= inb_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_z_ff     <= rsp_z_in;
      rsp_face_ff  <= rsp_face_in;
      rsp_layer_ff <= rsp_layer_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_face_x        = rsp_x_ff;
   assign rsp_face_y        = rsp_y_ff;
   assign rsp_face_z        = rsp_z_ff;
   assign rsp_face_id       = rsp_face_ff;
   assign rsp_texture_layer = rsp_layer_ff;
   assign rsp_last_face     = rsp_last_ff;

endmodule

// ===== hw/rtl/voxel_face_culling_unit.sv =====
// Top level of the voxel face culling unit: configuration registers and the front, queue
// and back ends. Depends on vfc_pkg, vfc_front, vfc_queue and vfc_back.
`timescale 1ns / 1ps

// The unit keeps a chunk of voxel block types in a single-port memory and answers two kinds
// of request: a write stores a type at (x, y, z), and a query reports the visible faces of
// that voxel as one result each, in the order front, right, top, left, bottom, back, with
// last_face set on the final one. After reset the unit runs a clearing pass that writes air
// (code 0) to all 2**(Y_W + 2*XZ_W) memory words, one word a cycle (16384 words at
// the default 16 x 64 x 16 chunk); req_ready stays low during that pass, while the
// configuration port works as usual. The front end takes a request in any cycle in which
// the two-entry command queue has room, so requests keep flowing while the back end is busy
// or a result is waiting. The back end owns the memory port, which sets the pace: a write
// goes straight to the memory, a query reads the voxel and then its six neighbors and emits
// one result per visible face, held while the result channel stalls; a query of an air
// voxel ends after that first read. Requests with coordinates outside the chunk are
// accepted and dropped. Register 0 (byte 0) is culling_on, register 1 (byte 4) is
// air_code; change them only while the unit is idle.

module voxel_face_culling_unit #(
   parameter int XZ_SIZE   = vfc_pkg::DEF_XZ_SIZE,
   parameter int Y_SIZE    = vfc_pkg::DEF_Y_SIZE,
   parameter int TYPE_ROWS = vfc_pkg::DEF_TYPE_ROWS,
   localparam int XZ_W = $clog2(XZ_SIZE),
   localparam int Y_W  = $clog2(Y_SIZE)
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel.
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_func,
   input  logic [XZ_W-1:0]             req_pos_x,
   input  logic [Y_W-1:0]              req_pos_y,
   input  logic [XZ_W-1:0]             req_pos_z,
   input  logic [vfc_pkg::TYPE_W-1:0]  req_block_type,
   // Result channel, one result per visible face.
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [XZ_W-1:0]             rsp_face_x,
   output logic [Y_W-1:0]              rsp_face_y,
   output logic [XZ_W-1:0]             rsp_face_z,
   output logic [vfc_pkg::FACE_W-1:0]  rsp_face_id,
   output logic [vfc_pkg::LAYER_W-1:0] rsp_texture_layer,
   output logic                        rsp_last_face,
   // Configuration port.
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import vfc_pkg::*;

   logic              culling_ff;
   logic              culling_in;
   logic [TYPE_W-1:0] air_ff;
   logic [TYPE_W-1:0] air_in;
   logic              csr_write;
   logic              reg_sel;

   logic              clearing;
   logic              push_valid;
   logic              push_ready;
   cmd_type           push_cmd;
   logic              pop_valid;
   logic              pop_ready;
   cmd_type           pop_cmd;

   // The register is picked by address bit 2; the byte offset bits are ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      culling_in = culling_ff;
      air_in     = air_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_CULLING_ON: culling_in = csr_pwdata[0];
            REG_AIR_CODE:   air_in     = csr_pwdata[TYPE_W-1:0];
            default:        culling_in = culling_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_CULLING_ON: csr_prdata = {31'b0, culling_ff};
         REG_AIR_CODE:   csr_prdata = {{(32 - TYPE_W){1'b0}}, air_ff};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         culling_ff <= 1'b1;
         air_ff     <= '0;
      end else begin
         culling_ff <= culling_in;
         air_ff     <= air_in;
      end
   end

   // Front end: takes requests, drops those outside the chunk, queues the rest.
   vfc_front #(
      .XZ_SIZE(XZ_SIZE),
      .Y_SIZE (Y_SIZE)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .req_block_type(req_block_type),
      .clearing      (clearing),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_cmd      (push_cmd)
   );

   // Decouples request intake from the memory sequencer.
   vfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_cmd  (push_cmd),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd)
   );

   // Back end: memory, clearing pass, neighbor reads and face emission.
   vfc_back #(
      .XZ_SIZE  (XZ_SIZE),
      .Y_SIZE   (Y_SIZE),
      .TYPE_ROWS(TYPE_ROWS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .culling_on       (culling_ff),
      .air_code         (air_ff),
      .clearing         (clearing),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_cmd          (pop_cmd),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_face_x       (rsp_face_x),
      .rsp_face_y       (rsp_face_y),
      .rsp_face_z       (rsp_face_z),
      .rsp_face_id      (rsp_face_id),
      .rsp_texture_layer(rsp_texture_layer),
      .rsp_last_face    (rsp_last_face)
   );

endmodule

// ===== hw/rtl/vfc_checker.sv =====
// Port-level assertions for the voxel face culling unit, and the bind that attaches them.
// Depends on vfc_pkg and voxel_face_culling_unit.
`timescale 1ns / 1ps

module vfc_checker #(
   parameter int XZ_W = 4,
   parameter int Y_W  = 6
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [XZ_W-1:0]             rsp_face_x,
   input logic [Y_W-1:0]              rsp_face_y,
   input logic [XZ_W-1:0]             rsp_face_z,
   input logic [vfc_pkg::FACE_W-1:0]  rsp_face_id,
   input logic [vfc_pkg::LAYER_W-1:0] rsp_texture_layer,
   input logic                        rsp_last_face
);
   import vfc_pkg::*;

   // The clearing pass holds off requests right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !req_ready)
      else $error("request accepted before the clearing pass");

   // Within a query the next face follows at once, for the same voxel, in rising order.
   a_query_faces: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_face |=>
         rsp_valid && rsp_face_x == $past(rsp_face_x) && rsp_face_y == $past(rsp_face_y) &&
         rsp_face_z == $past(rsp_face_z) && rsp_face_id > $past(rsp_face_id))
      else $error("face sequence of a query broken");

   // A stalled result holds its face, layer, last flag and x coordinate.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_face_id) &&
         $stable(rsp_texture_layer) && $stable(rsp_last_face) && $stable(rsp_face_x))
      else $error("stalled result changed");

   a_face_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_face_id <= FACE_BACK)
      else $error("face id out of range");

endmodule

bind voxel_face_culling_unit vfc_checker #(
   .XZ_W(XZ_W),
   .Y_W (Y_W)
) u_vfc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_face_x       (rsp_face_x),
   .rsp_face_y       (rsp_face_y),
   .rsp_face_z       (rsp_face_z),
   .rsp_face_id      (rsp_face_id),
   .rsp_texture_layer(rsp_texture_layer),
   .rsp_last_face    (rsp_last_face)
);

// ===== dv/tb.sv =====
// Self-checking testbench for voxel_face_culling_unit: directed table, then random phases.
// Depends on vfc_pkg for the operation, face and register codes; reads no files.
`timescale 1ns / 1ps

module tb;
   import vfc_pkg::*;

   localparam int XZ_SIZE       = 16;
   localparam int Y_SIZE        = 64;
   localparam int PERIOD        = 4;
   // Allowance for requests that keep the unit busy without producing a result: two
   // queued requests plus the one in the back end.
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS   = 42;
   localparam int PHASES        = 6;
   localparam int PRINT_CAP     = 100;

   typedef struct {
      op_type     op;
      logic [3:0] x;
      logic [5:0] y;
      logic [3:0] z;
      logic [7:0] btype;
   } voxel_req;

   typedef struct {
      logic [3:0] x;
      logic [5:0] y;
      logic [3:0] z;
      face_type   face;
      logic [4:0] layer;
      logic       last;
   } face_rec;

   typedef enum { ROW_REQUEST, ROW_CONFIG } row_kind;

   // One row of the directed table. Rows marked fixed carry their expected faces as a mask
   // with one layer for all of them; the others go through the predictor.
   typedef struct {
      row_kind    kind;
      voxel_req   req;
      bit         fixed;
      logic [5:0] face_mask;
      logic [4:0] layer;
      logic       reg_index;
      logic [7:0] reg_value;
   } plan_row;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [3:0]  req_pos_x = '0;
   logic [5:0]  req_pos_y = '0;
   logic [3:0]  req_pos_z = '0;
   logic [7:0]  req_block_type = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_face_x;
   logic [5:0]  rsp_face_y;
   logic [3:0]  rsp_face_z;
   logic [2:0]  rsp_face_id;
   logic [4:0]  rsp_texture_layer;
   logic        rsp_last_face;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow copy of the chunk and of the two registers, as the unit should hold them.
   bit [7:0]    voxel_mirror [0:XZ_SIZE*XZ_SIZE*Y_SIZE-1];
   bit          cull_enabled = 1'b1;
   bit [7:0]    air_type = 8'd0;

   // Faces still owed by the unit, oldest first.
   face_rec     pending_faces [$];
   int          mismatch_count = 0;
   // While set, neither side of the request and result channels inserts idle cycles.
   bit          steady_flow = 1'b0;

   voxel_face_culling_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_block_type    (req_block_type),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_face_x        (rsp_face_x),
      .rsp_face_y        (rsp_face_y),
      .rsp_face_z        (rsp_face_z),
      .rsp_face_id       (rsp_face_id),
      .rsp_texture_layer (rsp_texture_layer),
      .rsp_last_face     (rsp_last_face),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Hard stop well beyond the slowest legal run, including the clearing pass after reset.
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_CAP) begin
         $display("tb: mismatch at %0t ns: %s", $time, what);
      end
      mismatch_count++;
   endtask

   // Texture layers of one block type, indexed by face (front in the lowest slot).
   function automatic logic [5:0][4:0] layer_row(input logic [7:0] btype);
      logic [5:0][4:0] row;
      case (btype)
         8'd1:    row = {5'd2, 5'd3, 5'd2, 5'd1, 5'd2, 5'd2};
         8'd2:    row = {6{5'd4}};
         8'd3:    row = {6{5'd5}};
         8'd4:    row = {6{5'd3}};
         8'd5:    row = {6{5'd5}};
         8'd6:    row = {6{5'd6}};
         8'd7:    row = {6{5'd7}};
         8'd8:    row = {6{5'd8}};
         8'd9:    row = {6{5'd9}};
         8'd10:   row = {6{5'd10}};
         8'd11:   row = {6{5'd11}};
         8'd12:   row = {6{5'd12}};
         8'd13:   row = {6{5'd20}};
         default: row = '0;
      endcase
      return row;
   endfunction

   // A face is hidden on the chunk boundary or against any neighbor that is not air.
   function automatic bit face_blocked(input int x, input int y, input int z,
                                       input face_type face);
      int nx;
      int ny;
      int nz;
      nx = x;
      ny = y;
      nz = z;
      case (face)
         FACE_FRONT:  nz++;
         FACE_RIGHT:  nx++;
         FACE_TOP:    ny++;
         FACE_LEFT:   nx--;
         FACE_BOTTOM: ny--;
         default:     nz--;
      endcase
      if (nx < 0 || nx >= XZ_SIZE || ny < 0 || ny >= Y_SIZE || nz < 0 || nz >= XZ_SIZE) begin
         return 1'b1;
      end
      return voxel_mirror[ny * XZ_SIZE * XZ_SIZE + nx * XZ_SIZE + nz] != air_type;
   endfunction

   function automatic void push_faces(input voxel_req r, input logic [5:0] mask,
                                      input logic [5:0][4:0] layers);
      face_rec fr;
      for (int f = 0; f < FACES; f++) begin
         if (mask[f]) begin
            fr.x     = r.x;
            fr.y     = r.y;
            fr.z     = r.z;
            fr.face  = face_type'(f);
            fr.layer = layers[f];
            fr.last  = ((mask >> (f + 1)) == 6'd0);
            pending_faces.push_back(fr);
         end
      end
   endfunction

   // Applies one accepted request to the shadow chunk and queues the faces it should produce.
   function automatic void queue_visible_faces(input voxel_req r);
      logic [13:0] addr;
      logic [7:0]  stored;
      logic [5:0]  mask;
      addr = {r.y, r.x, r.z};
      if (r.op == OP_WRITE) begin
         voxel_mirror[addr] = r.btype;
         return;
      end
      stored = voxel_mirror[addr];
      if (stored == air_type) begin
         return;
      end
      for (int f = 0; f < FACES; f++) begin
         mask[f] = !cull_enabled || !face_blocked(r.x, r.y, r.z, face_type'(f));
      end
      push_faces(r, mask, layer_row(stored));
   endfunction

   function automatic plan_row req_row(input op_type op, input int x, input int y,
                                       input int z, input int btype);
      plan_row row;
      row.kind      = ROW_REQUEST;
      row.req.op    = op;
      row.req.x     = 4'(x);
      row.req.y     = 6'(y);
      row.req.z     = 4'(z);
      row.req.btype = 8'(btype);
      row.fixed     = 1'b0;
      row.face_mask = '0;
      row.layer     = '0;
      row.reg_index = REG_CULLING_ON;
      row.reg_value = '0;
      return row;
   endfunction

   function automatic plan_row fixed_row(input int x, input int y, input int z,
                                         input logic [5:0] mask, input logic [4:0] layer);
      plan_row row;
      row           = req_row(OP_QUERY, x, y, z, 0);
      row.fixed     = 1'b1;
      row.face_mask = mask;
      row.layer     = layer;
      return row;
   endfunction

   function automatic plan_row config_row(input logic index, input int value);
      plan_row row;
      row           = req_row(OP_WRITE, 0, 0, 0, 0);
      row.kind      = ROW_CONFIG;
      row.reg_index = index;
      row.reg_value = 8'(value);
      return row;
   endfunction

   // Presents one request, holding it until the unit takes it. The expected faces are
   // worked out at the accepting edge, so later writes never leak into earlier queries.
   task automatic drive_request(input voxel_req r, input bit fixed,
                                input logic [5:0] mask, input logic [4:0] layer);
      while (!steady_flow && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= r.op;
      req_pos_x      <= r.x;
      req_pos_y      <= r.y;
      req_pos_z      <= r.z;
      req_block_type <= r.btype;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      if (fixed) begin
         push_faces(r, mask, {6{layer}});
      end else begin
         queue_visible_faces(r);
      end
   endtask

   // Stops sending and waits until every owed face has arrived, then lets the unit settle.
   task automatic drain_faces(input int settle);
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_faces.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the access edge.
   task automatic write_register(input logic index, input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (index == REG_CULLING_ON) begin
         cull_enabled = value[0];
      end else begin
         air_type = value;
      end
      @(posedge clock);
   endtask

   // The result side stalls at random, except during the steady stretch.
   always @(posedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(99) >= 36);
   end

   // Every accepted result is matched against the oldest owed face, one field at a time.
   always @(posedge clock) begin : check_results
      face_rec want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_faces.size() == 0) begin
            report_mismatch($sformatf("unexpected face %0d of voxel (%0d,%0d,%0d)",
                                      rsp_face_id, rsp_face_x, rsp_face_y, rsp_face_z));
         end else begin
            want = pending_faces.pop_front();
            if (rsp_face_x !== want.x) begin
               report_mismatch($sformatf("face_x got %0d want %0d", rsp_face_x, want.x));
            end
            if (rsp_face_y !== want.y) begin
               report_mismatch($sformatf("face_y got %0d want %0d", rsp_face_y, want.y));
            end
            if (rsp_face_z !== want.z) begin
               report_mismatch($sformatf("face_z got %0d want %0d", rsp_face_z, want.z));
            end
            if (rsp_face_id !== want.face) begin
               report_mismatch($sformatf("face_id got %0d want %0d", rsp_face_id, want.face));
            end
            if (rsp_texture_layer !== want.layer) begin
               report_mismatch($sformatf("texture_layer got %0d want %0d",
                                         rsp_texture_layer, want.layer));
            end
            if (rsp_last_face !== want.last) begin
               report_mismatch($sformatf("last_face got %0d want %0d",
                                         rsp_last_face, want.last));
            end
         end
      end
   end

   initial begin
      plan_row  plan [$];
      voxel_req r;
      int       bx;
      int       by;
      int       bz;
      int       pick;

      // Directed table. Starts from the reset settings: culling on, air is code 0.
      // An untouched chunk is all air, so nothing comes back at either corner.
      plan.push_back(fixed_row(0, 0, 0, 6'b000000, 5'd0));
      plan.push_back(fixed_row(15, 63, 15, 6'b000000, 5'd0));
      // A lone block in a corner shows only the faces that point into the chunk.
      plan.push_back(req_row(OP_WRITE, 0, 0, 0, 2));
      plan.push_back(fixed_row(0, 0, 0, 6'b000111, 5'd4));
      plan.push_back(req_row(OP_WRITE, 15, 63, 15, 13));
      plan.push_back(fixed_row(15, 63, 15, 6'b111000, 5'd20));
      // Block type 1 has distinct top and bottom layers; then it gets walled in step by step.
      plan.push_back(req_row(OP_WRITE, 5, 10, 5, 1));
      plan.push_back(req_row(OP_QUERY, 5, 10, 5, 0));
      plan.push_back(req_row(OP_WRITE, 5, 11, 5, 3));
      plan.push_back(req_row(OP_WRITE, 6, 10, 5, 255));
      plan.push_back(req_row(OP_QUERY, 5, 10, 5, 0));
      plan.push_back(req_row(OP_QUERY, 6, 10, 5, 0));
      plan.push_back(req_row(OP_WRITE, 4, 10, 5, 14));
      plan.push_back(req_row(OP_WRITE, 5, 9, 5, 23));
      plan.push_back(req_row(OP_WRITE, 5, 10, 6, 24));
      plan.push_back(req_row(OP_WRITE, 5, 10, 4, 12));
      // Every neighbor is solid now, so the block shows nothing.
      plan.push_back(fixed_row(5, 10, 5, 6'b000000, 5'd0));
      // Types past the end of the table and zero rows both give layer 0.
      plan.push_back(req_row(OP_QUERY, 4, 10, 5, 0));
      plan.push_back(req_row(OP_QUERY, 5, 10, 6, 0));
      // With culling off, the corner block shows all six faces.
      plan.push_back(config_row(REG_CULLING_ON, 0));
      plan.push_back(fixed_row(0, 0, 0, 6'b111111, 5'd4));
      // Air moved to code 255: cleared voxels become solid type 0, and 255 turns to air.
      plan.push_back(config_row(REG_AIR_CODE, 255));
      plan.push_back(fixed_row(8, 30, 8, 6'b111111, 5'd0));
      plan.push_back(fixed_row(6, 10, 5, 6'b000000, 5'd0));
      plan.push_back(config_row(REG_CULLING_ON, 1));
      plan.push_back(fixed_row(8, 30, 8, 6'b000000, 5'd0));
      plan.push_back(req_row(OP_WRITE, 5, 10, 5, 255));
      plan.push_back(req_row(OP_QUERY, 5, 11, 5, 0));
      plan.push_back(config_row(REG_AIR_CODE, 0));

      // Reset once; the unit then clears its memory with req_ready low.
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CONFIG) begin
            drain_faces(SETTLE_CYCLES);
            write_register(plan[i].reg_index, plan[i].reg_value);
         end else begin
            drive_request(plan[i].req, plan[i].fixed, plan[i].face_mask, plan[i].layer);
         end
      end

      // Random phases, each under its own register settings. Most requests land in a small
      // window so writes and queries meet; a few go anywhere in the chunk.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_faces(SETTLE_CYCLES);
         case (phase)
            0: begin
               write_register(REG_CULLING_ON, 8'd0);
               write_register(REG_AIR_CODE, 8'd0);
            end
            1: begin
               write_register(REG_CULLING_ON, 8'd1);
               write_register(REG_AIR_CODE, 8'd255);
            end
            2: begin
               write_register(REG_CULLING_ON, 8'd0);
               write_register(REG_AIR_CODE, 8'd255);
            end
            3: begin
               write_register(REG_CULLING_ON, 8'd1);
               write_register(REG_AIR_CODE, 8'($urandom_range(1, 254)));
            end
            4: begin
               write_register(REG_CULLING_ON, 8'd0);
               write_register(REG_AIR_CODE, 8'($urandom_range(1, 254)));
            end
            default: begin
               write_register(REG_CULLING_ON, 8'd1);
               write_register(REG_AIR_CODE, 8'd0);
            end
         endcase
         // One whole phase runs without any idle cycles on either side.
         steady_flow = (phase == 3);
         // Windows often touch the chunk faces so boundary culling gets exercised.
         case ($urandom_range(2))
            0:       begin bx = 0;  by = 0;  bz = 0;  end
            1:       begin bx = 13; by = 61; bz = 13; end
            default: begin
               bx = $urandom_range(13);
               by = $urandom_range(61);
               bz = $urandom_range(13);
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Halfway through, hold off until the unit has delivered everything.
            if (n == PHASE_ITEMS / 2) begin
               drain_faces(0);
            end
            if ($urandom_range(99) < 10) begin
               r.op    = op_type'($urandom_range(1));
               r.x     = 4'($urandom_range(XZ_SIZE - 1));
               r.y     = 6'($urandom_range(Y_SIZE - 1));
               r.z     = 4'($urandom_range(XZ_SIZE - 1));
               r.btype = 8'($urandom_range(255));
            end else begin
               r.op = ($urandom_range(99) < 45) ? OP_WRITE : OP_QUERY;
               r.x  = 4'(bx + $urandom_range(2));
               r.y  = 6'(by + $urandom_range(2));
               r.z  = 4'(bz + $urandom_range(2));
               pick = $urandom_range(9);
               if (pick < 3) begin
                  r.btype = air_type;
               end else if (pick < 7) begin
                  r.btype = 8'($urandom_range(24));
               end else begin
                  r.btype = 8'($urandom_range(255));
               end
            end
            drive_request(r, 1'b0, 6'b000000, 5'd0);
         end
      end
      steady_flow = 1'b0;

      drain_faces(SETTLE_CYCLES);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
